[rtl/rgb_sharpen_3x3_filter_macros.svh]
// ----------------------------------------------------------------------------
// rgb_sharpen_3x3_filter_macros
// Assertion macros used by the sharpen filter RTL.
// ----------------------------------------------------------------------------
`ifndef RGB_SHARPEN_3X3_FILTER_MACROS_SVH
`define RGB_SHARPEN_3X3_FILTER_MACROS_SVH

// condition must hold in the same cycle as the trigger
`define RSF_ASSERT_HOLDS(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// condition must hold in the cycle after the trigger
`define RSF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/rsf_pkg.sv]
// ----------------------------------------------------------------------------
// rsf_pkg
// Types, constants and the sharpen kernel of the RGB 3x3 sharpen filter.
// ----------------------------------------------------------------------------
package rsf_pkg;

    // field widths
    localparam int PIX_W         = 8;
    localparam int FRAME_W_CFG_W = 11;
    localparam int FRAME_H_CFG_W = 13;
    localparam int CFG_DATA_W    = 13;
    localparam int CFG_IDX_W     = 1;

    // default geometry limits and register reset values
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int FRAME_W_RST    = 640;
    localparam int FRAME_H_RST    = 480;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // one pixel, red in the low byte
    typedef struct packed {
        logic [PIX_W-1:0] blue;
        logic [PIX_W-1:0] green;
        logic [PIX_W-1:0] red;
    } t_rgb;

    // one result item
    typedef struct packed {
        logic frame_last;
        t_rgb pix;
    } t_res;

    // one channel of a 3x3 window, row major, centre at index 4
    typedef logic [8:0][PIX_W-1:0] t_win;

    // line delay controls
    typedef struct packed {
        logic en;
        logic clr;
    } t_ld_ctrl;

    // 9 * centre minus the eight neighbours, clamped to 0..255
    function automatic logic [PIX_W-1:0] sharpen_ch(input t_win win);
        logic [PIX_W+2:0]        nsum;
        logic [PIX_W+3:0]        c9;
        logic signed [PIX_W+5:0] acc;
        logic [PIX_W-1:0]        res;
        nsum = '0;
        for (int k = 0; k < 9; k++) begin
            if (k != 4) begin
                nsum = nsum + (PIX_W+3)'(win[k]);
            end
        end
        c9  = ((PIX_W+4)'(win[4]) << 3) + (PIX_W+4)'(win[4]);
        acc = $signed({2'b00, c9}) - $signed({3'b000, nsum});
        if (acc < 0) begin
            res = '0;
        end else if (acc > 255) begin
            res = '1;
        end else begin
            res = acc[PIX_W-1:0];
        end
        return res;
    endfunction

endpackage

[rtl/rsf_cfg_if.sv]
// ----------------------------------------------------------------------------
// rsf_cfg_if
// Register write channel: index and data with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsf_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [rsf_pkg::CFG_IDX_W-1:0]   index;
    logic [rsf_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/rsf_pix_in_if.sv]
// ----------------------------------------------------------------------------
// rsf_pix_in_if
// Input pixel channel: RGB pixel plus flush flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsf_pix_in_if;
    logic                       valid;
    logic                       ready;
    logic [rsf_pkg::PIX_W-1:0]  red_in;
    logic [rsf_pkg::PIX_W-1:0]  green_in;
    logic [rsf_pkg::PIX_W-1:0]  blue_in;
    logic                       flush;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    output flush, input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    input flush, output ready);
endinterface

[rtl/rsf_pix_out_if.sv]
// ----------------------------------------------------------------------------
// rsf_pix_out_if
// Output pixel channel: RGB result plus frame end flag, valid/ready handshake.
// ----------------------------------------------------------------------------
interface rsf_pix_out_if;
    logic                       valid;
    logic                       ready;
    logic [rsf_pkg::PIX_W-1:0]  red_out;
    logic [rsf_pkg::PIX_W-1:0]  green_out;
    logic [rsf_pkg::PIX_W-1:0]  blue_out;
    logic                       frame_last;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output frame_last, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input frame_last, output ready);
endinterface

[rtl/rgb_sharpen_3x3_filter.sv]
// ----------------------------------------------------------------------------
// rgb_sharpen_3x3_filter
// Streaming 3x3 Laplacian sharpen for RGB pixels with two line delays.
// ----------------------------------------------------------------------------
// Usage:
//   i_pix takes pixels of a frame in raster order, then frame_width+1 flush
//   items to drain it. A flush item inside the frame is taken and ignored; a
//   pixel after the last one of the frame counts as a flush item.
//   o_pix gives one result per pixel, in raster order. Interior pixels get
//   9*centre minus the eight neighbours, clamped to 0..255; pixels of the
//   first and last rows and columns pass unchanged. frame_last marks the
//   final pixel, after which a new frame starts.
//   i_cfg writes frame_width (index 0) and frame_height (index 1); values
//   are clamped to 1..MAX_WIDTH and 1..MAX_HEIGHT, and a write restarts the
//   frame. ready on i_cfg is always high.
//   Throughput: one item per cycle while i_pix ready is high. The result
//   for pixel q is produced by the item frame_width+1 places after it and
//   leaves o_pix through the window register, then the output register.
//   Reset: registers go to 640 x 480, counters to the start of a frame;
//   the line memories are not cleared and need no clearing pass.
//   Stall: the output register and the pending window stage hold; i_pix
//   ready drops only when both are full and o_pix is not taken.
// ----------------------------------------------------------------------------
`include "rgb_sharpen_3x3_filter_macros.svh"

module rgb_sharpen_3x3_filter #(
    parameter int MAX_WIDTH  = rsf_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = rsf_pkg::MAX_HEIGHT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    rsf_cfg_if.sink       i_cfg,
    rsf_pix_in_if.sink    i_pix,
    rsf_pix_out_if.source o_pix
);

    localparam int WW = $clog2(MAX_WIDTH+1);
    localparam int HW = $clog2(MAX_HEIGHT+1);
    localparam int LW = $clog2(MAX_WIDTH+2);

    localparam int W_RST_INT = (rsf_pkg::FRAME_W_RST > MAX_WIDTH) ?
                               MAX_WIDTH : rsf_pkg::FRAME_W_RST;
    localparam int H_RST_INT = (rsf_pkg::FRAME_H_RST > MAX_HEIGHT) ?
                               MAX_HEIGHT : rsf_pkg::FRAME_H_RST;
    localparam logic [WW-1:0] W_RST = WW'(W_RST_INT);
    localparam logic [HW-1:0] H_RST = HW'(H_RST_INT);

    // configuration
    logic [WW-1:0] r_w;
    logic [HW-1:0] r_h;
    logic [WW-1:0] cfg_w;
    logic [HW-1:0] cfg_h;
    logic [rsf_pkg::FRAME_W_CFG_W-1:0] wv;
    logic [rsf_pkg::FRAME_H_CFG_W-1:0] hv;
    logic cfg_wr;

    // frame position
    logic [WW-1:0] r_in_col,  n_in_col;
    logic [HW-1:0] r_in_row,  n_in_row;
    logic [WW-1:0] r_out_col, n_out_col;
    logic [HW-1:0] r_out_row, n_out_row;
    logic [LW-1:0] r_lead,    n_lead;

    // window stage and output stage
    logic r_p_valid,  n_p_valid;
    logic r_p_border, n_p_border;
    logic r_p_last,   n_p_last;
    logic r_o_valid;
    rsf_pkg::t_res r_o_res;

    logic accept, frame_done, shift, pixel, lead_full, move;
    logic out_border, out_last;

    rsf_pkg::t_rgb in_px;
    rsf_pkg::t_rgb ld_a_q, ld_b_q;
    rsf_pkg::t_rgb r_b0, r_b1, r_b2, r_m1, r_m2, r_t1, r_t2;
    rsf_pkg::t_rgb sharp_px, res_px;
    rsf_pkg::t_rgb [8:0] win;
    rsf_pkg::t_win win_r, win_g, win_b;
    rsf_pkg::t_ld_ctrl ld_ctrl;

    // register clamp
    always_comb begin
        wv = i_cfg.data[rsf_pkg::FRAME_W_CFG_W-1:0];
        hv = i_cfg.data[rsf_pkg::FRAME_H_CFG_W-1:0];
        if (wv == '0) begin
            cfg_w = WW'(1);
        end else if (32'(wv) > MAX_WIDTH) begin
            cfg_w = WW'(MAX_WIDTH);
        end else begin
            cfg_w = WW'(wv);
        end
        if (hv == '0) begin
            cfg_h = HW'(1);
        end else if (32'(hv) > MAX_HEIGHT) begin
            cfg_h = HW'(MAX_HEIGHT);
        end else begin
            cfg_h = HW'(hv);
        end
    end

    assign i_cfg.ready = 1'b1;
    assign cfg_wr      = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w <= W_RST;
            r_h <= H_RST;
        end else if (cfg_wr) begin
            case (rsf_pkg::t_cfg_reg'(i_cfg.index))
                rsf_pkg::CFG_FRAME_WIDTH:  r_w <= cfg_w;
                rsf_pkg::CFG_FRAME_HEIGHT: r_h <= cfg_h;
                default: ;
            endcase
        end
    end

    // handshake and item classification
    assign move        = r_p_valid && (!r_o_valid || o_pix.ready);
    assign i_pix.ready = !r_p_valid || !r_o_valid || o_pix.ready;
    assign accept      = i_pix.valid && i_pix.ready;
    assign frame_done  = (r_in_row == r_h);
    assign shift       = accept && (frame_done || !i_pix.flush);
    assign pixel       = shift && !frame_done;
    assign lead_full   = (r_lead == (LW'(r_w) + LW'(1)));

    // border and frame end of the next result position
    assign out_last   = (r_out_col + WW'(1) == r_w) && (r_out_row + HW'(1) == r_h);
    assign out_border = (r_out_col == '0) || (r_out_row == '0) ||
                        (r_out_col + WW'(1) == r_w) || (r_out_row + HW'(1) == r_h);

    // position counters and pending result flags
    always_comb begin
        n_in_col   = r_in_col;
        n_in_row   = r_in_row;
        n_out_col  = r_out_col;
        n_out_row  = r_out_row;
        n_lead     = r_lead;
        n_p_valid  = r_p_valid;
        n_p_border = r_p_border;
        n_p_last   = r_p_last;
        if (move) begin
            n_p_valid = 1'b0;
        end
        if (cfg_wr) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
            n_lead    = '0;
        end else if (shift) begin
            if (pixel) begin
                if (r_in_col + WW'(1) == r_w) begin
                    n_in_col = '0;
                    n_in_row = r_in_row + HW'(1);
                end else begin
                    n_in_col = r_in_col + WW'(1);
                end
            end
            if (!lead_full) begin
                n_lead = r_lead + LW'(1);
            end
            n_p_valid  = lead_full;
            n_p_border = out_border;
            n_p_last   = out_last;
            if (lead_full) begin
                if (out_last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                    n_lead    = '0;
                end else if (r_out_col + WW'(1) == r_w) begin
                    n_out_col = '0;
                    n_out_row = r_out_row + HW'(1);
                end else begin
                    n_out_col = r_out_col + WW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col   <= '0;
            r_in_row   <= '0;
            r_out_col  <= '0;
            r_out_row  <= '0;
            r_lead     <= '0;
            r_p_valid  <= 1'b0;
            r_p_border <= 1'b0;
            r_p_last   <= 1'b0;
        end else begin
            r_in_col   <= n_in_col;
            r_in_row   <= n_in_row;
            r_out_col  <= n_out_col;
            r_out_row  <= n_out_row;
            r_lead     <= n_lead;
            r_p_valid  <= n_p_valid;
            r_p_border <= n_p_border;
            r_p_last   <= n_p_last;
        end
    end

    // line delays: one row, then one row less a pixel
    always_comb begin
        in_px.red   = i_pix.red_in;
        in_px.green = i_pix.green_in;
        in_px.blue  = i_pix.blue_in;
        ld_ctrl.en  = shift;
        ld_ctrl.clr = cfg_wr;
    end

    rsf_line_delay #(
        .DEPTH (MAX_WIDTH)
    ) u_ld_a (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ld_ctrl),
        .i_len   (r_w),
        .i_data  (in_px),
        .o_data  (ld_a_q)
    );

    rsf_line_delay #(
        .DEPTH (MAX_WIDTH)
    ) u_ld_b (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ld_ctrl),
        .i_len   (r_w - WW'(1)),
        .i_data  (ld_a_q),
        .o_data  (ld_b_q)
    );

    // window shift registers
    always_ff @(posedge i_clk) begin
        if (shift) begin
            r_b0 <= in_px;
            r_b1 <= r_b0;
            r_b2 <= r_b1;
            r_m1 <= ld_a_q;
            r_m2 <= r_m1;
            r_t1 <= ld_b_q;
            r_t2 <= r_t1;
        end
    end

    // kernel on the registered window
    always_comb begin
        win[0] = r_t2;
        win[1] = r_t1;
        win[2] = ld_b_q;
        win[3] = r_m2;
        win[4] = r_m1;
        win[5] = ld_a_q;
        win[6] = r_b2;
        win[7] = r_b1;
        win[8] = r_b0;
        for (int k = 0; k < 9; k++) begin
            win_r[k] = win[k].red;
            win_g[k] = win[k].green;
            win_b[k] = win[k].blue;
        end
        sharp_px.red   = rsf_pkg::sharpen_ch(win_r);
        sharp_px.green = rsf_pkg::sharpen_ch(win_g);
        sharp_px.blue  = rsf_pkg::sharpen_ch(win_b);
        res_px = r_p_border ? r_m1 : sharp_px;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (move) begin
            r_o_valid <= 1'b1;
        end else if (o_pix.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (move) begin
            r_o_res.pix        <= res_px;
            r_o_res.frame_last <= r_p_last;
        end
    end

    assign o_pix.valid      = r_o_valid;
    assign o_pix.red_out    = r_o_res.pix.red;
    assign o_pix.green_out  = r_o_res.pix.green;
    assign o_pix.blue_out   = r_o_res.pix.blue;
    assign o_pix.frame_last = r_o_res.frame_last;

    // checks
    `RSF_ASSERT_HOLDS(a_no_accept_when_full, i_clk, i_rst_n, r_p_valid && r_o_valid && !o_pix.ready, !i_pix.ready, "item taken while both result stages are full")
    `RSF_ASSERT_NEXT(a_pending_kept, i_clk, i_rst_n, r_p_valid && r_o_valid && !o_pix.ready, r_p_valid, "pending result lost during output stall")
    `RSF_ASSERT_HOLDS(a_pos_in_frame, i_clk, i_rst_n, 1'b1, (r_out_col < r_w) && (r_out_row < r_h) && (r_in_col < r_w) && (r_in_row <= r_h), "frame position out of range")
    `RSF_ASSERT_HOLDS(a_last_restarts, i_clk, i_rst_n, r_p_valid && r_p_last, (r_lead == '0) && (r_out_col == '0) && (r_out_row == '0) && (r_in_row == '0), "counters not restarted after frame end")
    `RSF_ASSERT_HOLDS(a_last_is_border, i_clk, i_rst_n, r_p_valid && r_p_last, r_p_border, "frame end pixel not treated as border")

endmodule

[rtl/rsf_line_delay.sv]
// ----------------------------------------------------------------------------
// rsf_line_delay
// Programmable item delay built on a read-first memory with a wrapping pointer.
// ----------------------------------------------------------------------------
module rsf_line_delay #(
    parameter int DEPTH = rsf_pkg::MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rsf_pkg::t_ld_ctrl            i_ctrl,
    input  logic [$clog2(DEPTH+1)-1:0]   i_len,
    input  rsf_pkg::t_rgb                i_data,
    output rsf_pkg::t_rgb                o_data
);

    localparam int AW    = $clog2(DEPTH);
    localparam int LEN_W = $clog2(DEPTH+1);

    rsf_pkg::t_rgb r_mem [DEPTH];
    rsf_pkg::t_rgb r_rd;
    logic [AW-1:0]    r_ptr;
    logic [AW-1:0]    n_ptr;
    logic [LEN_W-1:0] ptr_inc;

    // pointer walks 0 .. len-1, a length of zero or one holds it at zero
    always_comb begin
        ptr_inc = LEN_W'(r_ptr) + LEN_W'(1);
        n_ptr   = (ptr_inc >= i_len) ? '0 : AW'(ptr_inc);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
        end else if (i_ctrl.clr) begin
            r_ptr <= '0;
        end else if (i_ctrl.en) begin
            r_ptr <= n_ptr;
        end
    end

    // read old entry, then overwrite it with the new item
    always_ff @(posedge i_clk) begin
        if (i_ctrl.en) begin
            r_rd         <= r_mem[r_ptr];
            r_mem[r_ptr] <= i_data;
        end
    end

    assign o_data = r_rd;

endmodule
